/* sv/planar_pose_frame_transform_macros.svh */
// Assertion macros for the planar pose frame transform.
// Taken in by the top level; needs nothing else.
`ifndef PLANAR_POSE_FRAME_TRANSFORM_MACROS_SVH
`define PLANAR_POSE_FRAME_TRANSFORM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPFT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppft: same-cycle check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define PPFT_ASSERT_AFTER(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ## (n) (cons)) \
    else $error("ppft: delayed check failed");

`endif

/* sv/ppft_pkg.sv */
// Shared types, widths and tables for the planar pose frame transform.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ppft_pkg;

  localparam int POS_BITS          = 32;
  localparam int ANGLE_BITS        = 16;
  localparam int PHASE_W           = 32;   // one turn is 2^PHASE_W
  localparam int CS_W              = 32;   // sin/cos, signed Q2.30
  localparam int CS_FRAC           = 30;
  localparam int XY_W              = CS_W + 2;
  localparam int AB_W              = POS_BITS + 1;
  localparam int PROD_W            = AB_W + CS_W;
  localparam int SUM_W             = PROD_W + 2;
  localparam int MAX_CORDIC_STAGES = 24;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(652032874);

  typedef struct packed {
    logic                         kind;
    logic signed [POS_BITS-1:0]   ref_x;
    logic signed [POS_BITS-1:0]   ref_y;
    logic signed [ANGLE_BITS-1:0] ref_heading;
    logic signed [POS_BITS-1:0]   tgt_x;
    logic signed [POS_BITS-1:0]   tgt_y;
    logic signed [ANGLE_BITS-1:0] tgt_heading;
    logic signed [POS_BITS-1:0]   tgt_curvature;
    logic signed [POS_BITS-1:0]   tgt_arclength;
  } pose_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0]   out_x;
    logic signed [POS_BITS-1:0]   out_y;
    logic signed [ANGLE_BITS-1:0] out_heading;
    logic signed [POS_BITS-1:0]   out_curvature;
    logic signed [POS_BITS-1:0]   out_arclength;
  } result_t;

  // Operands and pass-through fields that ride alongside the CORDIC.
  typedef struct packed {
    logic signed [AB_W-1:0]       a;
    logic signed [AB_W-1:0]       b;
    logic signed [POS_BITS-1:0]   off_x;
    logic signed [POS_BITS-1:0]   off_y;
    logic signed [ANGLE_BITS-1:0] heading;
    logic signed [POS_BITS-1:0]   curvature;
    logic signed [POS_BITS-1:0]   arclength;
  } work_t;

  // Folded phase and the sign fix-ups applied after the CORDIC.
  typedef struct packed {
    logic signed [PHASE_W-1:0] phase;
    logic                      neg_cos;
    logic                      neg_sin;
  } fold_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [PHASE_W-1:0] atan_turn(input int idx);
    logic signed [PHASE_W-1:0] v;
    case (idx)
      0:       v = 32'sd536870912;
      1:       v = 32'sd316933406;
      2:       v = 32'sd167458907;
      3:       v = 32'sd85004756;
      4:       v = 32'sd42667331;
      5:       v = 32'sd21354465;
      6:       v = 32'sd10679838;
      7:       v = 32'sd5340245;
      8:       v = 32'sd2670163;
      9:       v = 32'sd1335087;
      10:      v = 32'sd667544;
      11:      v = 32'sd333772;
      12:      v = 32'sd166886;
      13:      v = 32'sd83443;
      14:      v = 32'sd41722;
      15:      v = 32'sd20861;
      16:      v = 32'sd10430;
      17:      v = 32'sd5215;
      18:      v = 32'sd2608;
      19:      v = 32'sd1304;
      20:      v = 32'sd652;
      21:      v = 32'sd326;
      22:      v = 32'sd163;
      23:      v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/ppft_prep.sv */
// Entry stage: folds the reference heading into a CORDIC phase and forms
// the rotation operands and pass-through fields. Depends on ppft_pkg.
`timescale 1ns / 1ps

module ppft_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ppft_pkg::pose_t pose,
  output logic            out_valid,
  output ppft_pkg::fold_t fold,
  output ppft_pkg::work_t work
);

  localparam int SHIFT = ppft_pkg::PHASE_W - ppft_pkg::ANGLE_BITS;
  localparam logic signed [ppft_pkg::PHASE_W-1:0] QUARTER =
    ppft_pkg::PHASE_W'(1) << (ppft_pkg::PHASE_W - 2);

  logic signed [ppft_pkg::PHASE_W-1:0] raw;
  logic                                wrap;
  ppft_pkg::fold_t                     fold_next;
  ppft_pkg::work_t                     work_next;

  always_comb begin
    raw  = {pose.ref_heading, {SHIFT{1'b0}}};
    wrap = (raw > QUARTER) || (raw < -QUARTER);
    // a half turn either way is a toggle of the top phase bit
    fold_next.phase   = wrap ? {~raw[ppft_pkg::PHASE_W-1], raw[ppft_pkg::PHASE_W-2:0]} : raw;
    fold_next.neg_cos = wrap;
    fold_next.neg_sin = wrap ^ pose.kind;

    work_next.a = ppft_pkg::AB_W'(pose.tgt_x) -
                  (pose.kind ? ppft_pkg::AB_W'(pose.ref_x) : '0);
    work_next.b = ppft_pkg::AB_W'(pose.tgt_y) -
                  (pose.kind ? ppft_pkg::AB_W'(pose.ref_y) : '0);
    work_next.off_x     = pose.kind ? '0 : pose.ref_x;
    work_next.off_y     = pose.kind ? '0 : pose.ref_y;
    work_next.heading   = pose.kind ? pose.tgt_heading - pose.ref_heading
                                    : pose.tgt_heading + pose.ref_heading;
    work_next.curvature = pose.tgt_curvature;
    work_next.arclength = pose.kind ? '0 : pose.tgt_arclength;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    fold <= fold_next;
    work <= work_next;
  end

endmodule

/* sv/ppft_cordic.sv */
// Pipelined rotation-mode CORDIC, one stage per iteration, plus an output
// stage that applies the sign fix-ups. Depends on ppft_pkg.
`timescale 1ns / 1ps

module ppft_cordic #(
  parameter int STAGES = ppft_pkg::DEF_CORDIC_STAGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  ppft_pkg::fold_t                  fold,
  input  ppft_pkg::work_t                  in_work,
  output logic                             out_valid,
  output logic signed [ppft_pkg::CS_W-1:0] cos_v,
  output logic signed [ppft_pkg::CS_W-1:0] sin_v,
  output ppft_pkg::work_t                  out_work
);

  logic [STAGES:0]                      vld;
  logic signed [ppft_pkg::XY_W-1:0]     xs   [STAGES+1];
  logic signed [ppft_pkg::XY_W-1:0]     ys   [STAGES+1];
  logic signed [ppft_pkg::PHASE_W-1:0]  zs   [STAGES+1];
  logic [STAGES:0]                      ncos;
  logic [STAGES:0]                      nsin;
  ppft_pkg::work_t                      wk   [STAGES+1];

  assign vld[0]  = in_valid;
  assign xs[0]   = ppft_pkg::INV_GAIN;
  assign ys[0]   = '0;
  assign zs[0]   = fold.phase;
  assign ncos[0] = fold.neg_cos;
  assign nsin[0] = fold.neg_sin;
  assign wk[0]   = in_work;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ppft_pkg::PHASE_W-1:0] ATAN = ppft_pkg::atan_turn(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ATAN;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ATAN;
      end
      ncos[i+1] <= ncos[i];
      nsin[i+1] <= nsin[i];
      wk[i+1]   <= wk[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[STAGES];
    end
  end

  // negate for the folded half turn; sine also for the inverse rotation
  always_ff @(posedge clk) begin
    cos_v    <= ppft_pkg::CS_W'(ncos[STAGES] ? -xs[STAGES] : xs[STAGES]);
    sin_v    <= ppft_pkg::CS_W'(nsin[STAGES] ? -ys[STAGES] : ys[STAGES]);
    out_work <= wk[STAGES];
  end

endmodule

/* sv/ppft_rotate.sv */
// Rotation back end: four products, rounded sums, and offset with saturation,
// one register stage each. Depends on ppft_pkg.
`timescale 1ns / 1ps

module ppft_rotate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [ppft_pkg::CS_W-1:0] cos_v,
  input  logic signed [ppft_pkg::CS_W-1:0] sin_v,
  input  ppft_pkg::work_t                  work,
  output logic                             done,
  output ppft_pkg::result_t                result
);

  localparam int PW    = ppft_pkg::PROD_W;
  localparam int SW    = ppft_pkg::SUM_W;
  localparam int FRAC  = ppft_pkg::CS_FRAC;
  localparam int TW    = SW - FRAC + 1;
  localparam int PB    = ppft_pkg::POS_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC - 1);

  logic                 v1;
  logic                 v2;
  logic signed [PW-1:0] p_ac;
  logic signed [PW-1:0] p_bs;
  logic signed [PW-1:0] p_as;
  logic signed [PW-1:0] p_bc;
  ppft_pkg::work_t      w1;
  ppft_pkg::work_t      w2;
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic signed [TW-1:0] tx;
  logic signed [TW-1:0] ty;

  function automatic logic signed [PB-1:0] sat_pos(input logic signed [TW-1:0] v);
    logic signed [PB-1:0] r;
    if (v[TW-1:PB-1] == '0 || v[TW-1:PB-1] == '1) begin
      r = v[PB-1:0];
    end else begin
      r = {v[TW-1], {(PB-1){~v[TW-1]}}};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2;
    end
  end

  // x = a*cos - b*sin, y = a*sin + b*cos (sine already sign-adjusted)
  always_ff @(posedge clk) begin
    p_ac <= PW'(work.a) * PW'(cos_v);
    p_bs <= PW'(work.b) * PW'(sin_v);
    p_as <= PW'(work.a) * PW'(sin_v);
    p_bc <= PW'(work.b) * PW'(cos_v);
    w1   <= work;
  end

  always_ff @(posedge clk) begin
    sx <= SW'(p_ac) - SW'(p_bs) + HALF;
    sy <= SW'(p_as) + SW'(p_bc) + HALF;
    w2 <= w1;
  end

  always_comb begin
    tx = TW'($signed(sx[SW-1:FRAC])) + TW'(w2.off_x);
    ty = TW'($signed(sy[SW-1:FRAC])) + TW'(w2.off_y);
  end

  always_ff @(posedge clk) begin
    result.out_x         <= sat_pos(tx);
    result.out_y         <= sat_pos(ty);
    result.out_heading   <= w2.heading;
    result.out_curvature <= w2.curvature;
    result.out_arclength <= w2.arclength;
  end

endmodule

/* sv/planar_pose_frame_transform.sv */
// Top level of the planar pose frame transform: entry stage, CORDIC and
// rotation back end. Depends on ppft_pkg and the three ppft_* modules.
//
//   channel   handshake             payload
//   input     start, busy           pose   (ppft_pkg::pose_t)
//   output    done (one-cycle)      result (ppft_pkg::result_t)
//
// One word is accepted every cycle while busy is low; its result passes through
// entry, one stage per CORDIC iteration, sign fix-up, multiply, sum, and
// offset and saturate. busy is high only during reset.
// Reset clears the valid bits of every stage; words in flight are dropped.
// The receiver cannot hold results off, so the pipeline never stalls.
`timescale 1ns / 1ps
`include "planar_pose_frame_transform_macros.svh"

module planar_pose_frame_transform #(
  parameter int CORDIC_STAGES = ppft_pkg::DEF_CORDIC_STAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ppft_pkg::pose_t   pose,
  output logic              done,
  output ppft_pkg::result_t result
);

  localparam int LAT = CORDIC_STAGES + 5;

  logic                             accept;
  logic                             prep_valid;
  ppft_pkg::fold_t                  prep_fold;
  ppft_pkg::work_t                  prep_work;
  logic                             cor_valid;
  logic signed [ppft_pkg::CS_W-1:0] cor_cos;
  logic signed [ppft_pkg::CS_W-1:0] cor_sin;
  ppft_pkg::work_t                  cor_work;

  assign busy   = rst;
  assign accept = start && !busy;

  ppft_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pose      (pose),
    .out_valid (prep_valid),
    .fold      (prep_fold),
    .work      (prep_work)
  );

  ppft_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .fold      (prep_fold),
    .in_work   (prep_work),
    .out_valid (cor_valid),
    .cos_v     (cor_cos),
    .sin_v     (cor_sin),
    .out_work  (cor_work)
  );

  ppft_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cor_valid),
    .cos_v    (cor_cos),
    .sin_v    (cor_sin),
    .work     (cor_work),
    .done     (done),
    .result   (result)
  );

  `PPFT_ASSERT_AFTER(a_word_out, clk, rst, accept, LAT, done)
  `PPFT_ASSERT_NOW(a_no_spurious, clk, rst, done, $past(accept, LAT))
  `PPFT_ASSERT_AFTER(a_inv_arc_zero, clk, rst, accept && pose.kind, LAT, result.out_arclength == '0)
  `PPFT_ASSERT_AFTER(a_curv_pass, clk, rst, accept, LAT, result.out_curvature == $past(pose.tgt_curvature, LAT))

endmodule
